FILE: rtl/core/cpd_pkg.sv
// shared constants, control word layout, microcode program and crc step for the deframer
package cpd_pkg;

   localparam int FRAME_LEN     = 68;
   localparam int PAYLOAD_WORDS = 16;
   localparam int ADDR_W        = 7;
   localparam int WCNT_W        = 5;
   localparam int IDX_W         = 4;
   localparam int PC_W          = 4;
   localparam int COND_W        = 4;

   localparam logic [7:0]  HDR0     = 8'd117;
   localparam logic [7:0]  HDR1     = 8'd84;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // jump conditions
   localparam logic [COND_W-1:0] COND_NONE       = 4'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS     = 4'd1;
   localparam logic [COND_W-1:0] COND_FULL       = 4'd2;
   localparam logic [COND_W-1:0] COND_PTR_END    = 4'd3;
   localparam logic [COND_W-1:0] COND_CRC_OK     = 4'd4;
   localparam logic [COND_W-1:0] COND_FOUND      = 4'd5;
   localparam logic [COND_W-1:0] COND_OUT_BUSY   = 4'd6;
   localparam logic [COND_W-1:0] COND_WORD_FULL  = 4'd7;
   localparam logic [COND_W-1:0] COND_WORDS_DONE = 4'd8;

   // read pointer load select
   localparam logic [1:0] PTR_KEEP = 2'd0;
   localparam logic [1:0] PTR_ZERO = 2'd1;
   localparam logic [1:0] PTR_TWO  = 2'd2;
   localparam logic [1:0] PTR_HIT  = 2'd3;

   // fill count operation
   localparam logic [1:0] FILL_KEEP = 2'd0;
   localparam logic [1:0] FILL_ZERO = 2'd1;
   localparam logic [1:0] FILL_TAIL = 2'd2;
   localparam logic [1:0] FILL_COPY = 2'd3;

   // program steps
   localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [PC_W-1:0] STEP_CRC_PREP  = 4'd1;
   localparam logic [PC_W-1:0] STEP_CRC_RUN   = 4'd2;
   localparam logic [PC_W-1:0] STEP_DECIDE    = 4'd3;
   localparam logic [PC_W-1:0] STEP_FAIL      = 4'd4;
   localparam logic [PC_W-1:0] STEP_TAIL      = 4'd5;
   localparam logic [PC_W-1:0] STEP_EMIT_PREP = 4'd6;
   localparam logic [PC_W-1:0] STEP_EMIT_RUN  = 4'd7;
   localparam logic [PC_W-1:0] STEP_EMIT_PUT  = 4'd8;
   localparam logic [PC_W-1:0] STEP_EMIT_CHK  = 4'd9;
   localparam logic [PC_W-1:0] STEP_FINISH    = 4'd10;
   localparam logic [PC_W-1:0] STEP_COPY_PREP = 4'd11;
   localparam logic [PC_W-1:0] STEP_COPY_RUN  = 4'd12;
   localparam logic [PC_W-1:0] STEP_EMIT_RD   = 4'd13;

   typedef struct packed {
      logic              take;
      logic              rd;
      logic [1:0]        ptr_ld;
      logic              crc_init;
      logic              crc_run;
      logic              word_shift;
      logic              put;
      logic              wcnt_clr;
      logic [1:0]        fill_op;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   jmp;
      logic [PC_W-1:0]   nxt;
   } ctrl_type;

   typedef struct packed {
      logic full;
      logic ptr_end;
      logic crc_ok;
      logic found;
      logic out_busy;
      logic word_full;
      logic words_done;
   } status_type;

   function automatic ctrl_type cpd_ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '0;
      unique case (pc)
         STEP_IDLE: begin
            w.take = 1'b1;
            w.cond = COND_FULL;
            w.jmp  = STEP_CRC_PREP;
            w.nxt  = STEP_IDLE;
         end
         STEP_CRC_PREP: begin
            w.ptr_ld   = PTR_ZERO;
            w.rd       = 1'b1;
            w.crc_init = 1'b1;
            w.nxt      = STEP_CRC_RUN;
         end
         STEP_CRC_RUN: begin
            w.rd      = 1'b1;
            w.crc_run = 1'b1;
            w.cond    = COND_PTR_END;
            w.jmp     = STEP_DECIDE;
            w.nxt     = STEP_CRC_RUN;
         end
         STEP_DECIDE: begin
            w.cond = COND_CRC_OK;
            w.jmp  = STEP_EMIT_PREP;
            w.nxt  = STEP_FAIL;
         end
         STEP_FAIL: begin
            w.cond = COND_FOUND;
            w.jmp  = STEP_COPY_PREP;
            w.nxt  = STEP_TAIL;
         end
         STEP_TAIL: begin
            w.fill_op = FILL_TAIL;
            w.cond    = COND_ALWAYS;
            w.jmp     = STEP_IDLE;
         end
         STEP_EMIT_PREP: begin
            w.ptr_ld   = PTR_TWO;
            w.rd       = 1'b1;
            w.wcnt_clr = 1'b1;
            w.nxt      = STEP_EMIT_RUN;
         end
         STEP_EMIT_RUN: begin
            w.rd         = 1'b1;
            w.word_shift = 1'b1;
            w.cond       = COND_WORD_FULL;
            w.jmp        = STEP_EMIT_PUT;
            w.nxt        = STEP_EMIT_RUN;
         end
         STEP_EMIT_PUT: begin
            w.put  = 1'b1;
            w.cond = COND_OUT_BUSY;
            w.jmp  = STEP_EMIT_PUT;
            w.nxt  = STEP_EMIT_CHK;
         end
         STEP_EMIT_CHK: begin
            w.cond = COND_WORDS_DONE;
            w.jmp  = STEP_FINISH;
            w.nxt  = STEP_EMIT_RD;
         end
         STEP_FINISH: begin
            w.fill_op = FILL_ZERO;
            w.cond    = COND_ALWAYS;
            w.jmp     = STEP_IDLE;
         end
         STEP_COPY_PREP: begin
            w.ptr_ld  = PTR_HIT;
            w.rd      = 1'b1;
            w.fill_op = FILL_ZERO;
            w.nxt     = STEP_COPY_RUN;
         end
         STEP_COPY_RUN: begin
            w.rd      = 1'b1;
            w.fill_op = FILL_COPY;
            w.cond    = COND_PTR_END;
            w.jmp     = STEP_IDLE;
            w.nxt     = STEP_COPY_RUN;
         end
         STEP_EMIT_RD: begin
            w.rd  = 1'b1;
            w.nxt = STEP_EMIT_RUN;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.jmp  = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // one byte of reflected crc-16
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/cpd_seq.sv
// microcode sequencer: step counter, control rom lookup and conditional jumps
module cpd_seq
   import cpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       taken
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;

   assign ctrl = cpd_ucode(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:       taken = 1'b0;
         COND_ALWAYS:     taken = 1'b1;
         COND_FULL:       taken = status.full;
         COND_PTR_END:    taken = status.ptr_end;
         COND_CRC_OK:     taken = status.crc_ok;
         COND_FOUND:      taken = status.found;
         COND_OUT_BUSY:   taken = status.out_busy;
         COND_WORD_FULL:  taken = status.word_full;
         COND_WORDS_DONE: taken = status.words_done;
         default:         taken = 1'b0;
      endcase
   end

   assign pc_in = taken ? ctrl.jmp : ctrl.nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: rtl/core/cpd_datapath.sv
// datapath: frame memory, pointers, crc and header search, word assembly and result register
module cpd_datapath
   import cpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl,
   input  logic             taken,
   input  logic             req_tvalid,
   input  logic [7:0]       req_byte,
   input  logic             rsp_tready,
   output status_type       status,
   output logic             rsp_valid,
   output logic [IDX_W-1:0] rsp_index,
   output logic [31:0]      rsp_word,
   output logic             rsp_last
);

   logic [7:0]        frame_mem [FRAME_LEN];
   logic [7:0]        rd_data_ff;

   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] hit_ff, hit_in;
   logic              found_ff, found_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        prev_ff, prev_in;
   logic [31:0]       word_ff, word_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic              out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]  out_index_ff;
   logic [31:0]       out_word_ff;
   logic              out_last_ff;

   logic              accept;
   logic              store;
   logic              drop_clear;
   logic              copy_wr;
   logic              wr_en;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              load_out;
   logic              pair_hit;

   assign accept     = req_tvalid & ctrl.take;
   assign drop_clear = accept && (fill_ff == ADDR_W'(1)) && (req_byte != HDR1);
   assign store      = accept && !((fill_ff == '0) && (req_byte != HDR0)) && !drop_clear;
   assign copy_wr    = (ctrl.fill_op == FILL_COPY);
   assign wr_en      = store | copy_wr;
   assign wr_data    = store ? req_byte : rd_data_ff;

   // read address, with an optional pointer reload in the same step
   always_comb begin
      case (ctrl.ptr_ld)
         PTR_ZERO: rd_addr = '0;
         PTR_TWO:  rd_addr = ADDR_W'(2);
         PTR_HIT:  rd_addr = hit_ff;
         default:  rd_addr = ptr_ff;
      endcase
   end

   assign rd_en  = ctrl.rd & ~taken;
   assign ptr_in = rd_en ? rd_addr + ADDR_W'(1) : ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[fill_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_comb begin
      if (store || copy_wr) begin
         fill_in = fill_ff + ADDR_W'(1);
      end else if (drop_clear) begin
         fill_in = '0;
      end else begin
         case (ctrl.fill_op)
            FILL_ZERO: fill_in = '0;
            FILL_TAIL: fill_in = ADDR_W'(prev_ff == HDR0);
            default:   fill_in = fill_ff;
         endcase
      end
   end

   // crc over the held frame, and first header pair at offsets two and up
   assign pair_hit = ctrl.crc_run && !found_ff && (prev_ff == HDR0) && (rd_data_ff == HDR1)
                     && (ptr_ff >= ADDR_W'(4));

   always_comb begin
      crc_in   = crc_ff;
      prev_in  = prev_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      if (ctrl.crc_init) begin
         crc_in   = CRC_INIT;
         found_in = 1'b0;
      end else if (ctrl.crc_run) begin
         crc_in  = crc_byte(crc_ff, rd_data_ff);
         prev_in = rd_data_ff;
         if (pair_hit) begin
            found_in = 1'b1;
            hit_in   = ptr_ff - ADDR_W'(2);
         end
      end
   end

   assign word_in  = ctrl.word_shift ? {rd_data_ff, word_ff[31:8]} : word_ff;
   assign load_out = ctrl.put & ~taken;

   always_comb begin
      if (ctrl.wcnt_clr) begin
         wcnt_in = '0;
      end else if (load_out) begin
         wcnt_in = wcnt_ff + WCNT_W'(1);
      end else begin
         wcnt_in = wcnt_ff;
      end
   end

   assign out_valid_in = load_out | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ptr_ff       <= '0;
         found_ff     <= 1'b0;
         wcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         found_ff     <= found_in;
         wcnt_ff      <= wcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      prev_ff <= prev_in;
      hit_ff  <= hit_in;
      word_ff <= word_in;
      if (load_out) begin
         out_index_ff <= wcnt_ff[IDX_W-1:0];
         out_word_ff  <= word_ff;
         out_last_ff  <= (wcnt_ff == WCNT_W'(PAYLOAD_WORDS - 1));
      end
   end

   assign status.full       = store && (fill_ff == ADDR_W'(FRAME_LEN - 1));
   assign status.ptr_end    = (ptr_ff == ADDR_W'(FRAME_LEN));
   assign status.crc_ok     = (crc_ff == 16'h0000);
   assign status.found      = found_ff;
   assign status.out_busy   = out_valid_ff & ~rsp_tready;
   assign status.word_full  = (ptr_ff[1:0] == 2'b10);
   assign status.words_done = (wcnt_ff == WCNT_W'(PAYLOAD_WORDS));

   assign rsp_valid = out_valid_ff;
   assign rsp_index = out_index_ff;
   assign rsp_word  = out_word_ff;
   assign rsp_last  = out_last_ff;

endmodule

FILE: rtl/core/calibration_packet_deframer.sv
// top level of the crc-checked calibration packet deframer
//
//  channel   dir   handshake                  payload
//  req       in    req_tvalid / req_tready    req_tdata[7:0] = rx_byte
//  rsp       out   rsp_tvalid / rsp_tready    rsp_tdata = word_index, word_value; rsp_tlast
//
//  bytes are taken only while the sequencer waits in its idle step
//  after the 68th byte of a frame a crc pass reads the whole frame memory,
//  then on a good crc: four reads, put and check per payload word, and a finish step;
//  on a bad crc with a header pair at offset i, the bytes from i on are copied down
//  passes share the frame memory's single read port; crc and copy read one byte per cycle
//  reset is synchronous; no clearing pass, the frame memory is only read where written
//  a stalled result holds the sequencer in its put step, input stays blocked meanwhile
module calibration_packet_deframer
   import cpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // response: payload words of an accepted frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] word_index, [35:4] word_value, [39:36] zero
   output logic        rsp_tlast    // last_word
);

   ctrl_type         ctrl;
   status_type       status;
   logic             taken;
   logic [IDX_W-1:0] rsp_index;
   logic [31:0]      rsp_word;

   // control program and step counter
   cpd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .taken  (taken)
   );

   // frame memory, crc, resync search and result register
   cpd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .taken      (taken),
      .req_tvalid (req_tvalid),
      .req_byte   (req_tdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_index  (rsp_index),
      .rsp_word   (rsp_word),
      .rsp_last   (rsp_tlast)
   );

   // bytes only enter in the idle step
   assign req_tready = ctrl.take;

   assign rsp_tdata = {4'b0000, rsp_word, rsp_index};

endmodule

FILE: test/cpd_word_checker.sv
// watches both channels of the deframer, predicts payload words and compares them
`timescale 1ns / 1ps

module cpd_word_checker
   import cpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [3:0] word_index, [35:4] word_value
   input  logic        rsp_tlast,   // last_word
   output int          mismatches,
   output int          pending,
   output int          words_predicted
);

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [31:0]      value;
      logic             last;
   } payload_word_type;

   payload_word_type word_queue[$];

   // own copy of the frame being assembled
   logic [7:0] rx_frame[FRAME_LEN];
   int         rx_fill;

   function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   task automatic take_byte(input logic [7:0] b);
      logic [15:0]      crc;
      int               hit;
      payload_word_type w;
      if (rx_fill >= FRAME_LEN) rx_fill = 0;
      if (rx_fill == 0 && b != HDR0) return;
      if (rx_fill == 1 && b != HDR1) begin
         rx_fill = 0;
         return;
      end
      rx_frame[rx_fill] = b;
      rx_fill++;
      if (rx_fill < FRAME_LEN) return;
      crc = CRC_INIT;
      for (int i = 0; i < FRAME_LEN; i++) crc = crc16_next(crc, rx_frame[i]);
      if (crc != 16'h0000) begin
         // look for a fresh header pair inside the failed frame
         hit = -1;
         for (int i = 2; i < FRAME_LEN - 1; i++)
            if (hit < 0 && rx_frame[i] == HDR0 && rx_frame[i+1] == HDR1) hit = i;
         if (hit >= 0) begin
            rx_fill = FRAME_LEN - hit;
            for (int j = 0; j < rx_fill; j++) rx_frame[j] = rx_frame[j+hit];
         end else if (rx_frame[FRAME_LEN-1] == HDR0) begin
            rx_frame[0] = HDR0;
            rx_fill = 1;
         end else begin
            rx_fill = 0;
         end
      end else begin
         for (int n = 0; n < PAYLOAD_WORDS; n++) begin
            w.index = n[IDX_W-1:0];
            w.value = {rx_frame[5+4*n], rx_frame[4+4*n], rx_frame[3+4*n], rx_frame[2+4*n]};
            w.last  = (n == PAYLOAD_WORDS - 1);
            word_queue.push_back(w);
         end
         words_predicted += PAYLOAD_WORDS;
         rx_fill = 0;
      end
   endtask

   task automatic check_word(input logic [39:0] data, input logic last);
      payload_word_type w;
      if (word_queue.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected word: index %0d value %08h last %0b",
                     data[3:0], data[35:4], last);
         mismatches++;
         return;
      end
      w = word_queue.pop_front();
      if (data[3:0] !== w.index || data[35:4] !== w.value || last !== w.last) begin
         if (mismatches < 10)
            $display("word mismatch: expected index %0d value %08h last %0b, got %0d %08h %0b",
                     w.index, w.value, w.last, data[3:0], data[35:4], last);
         mismatches++;
      end
   endtask

   initial begin
      mismatches      = 0;
      pending         = 0;
      words_predicted = 0;
      rx_fill         = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) take_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_word(rsp_tdata, rsp_tlast);
         pending = word_queue.size();
      end
   end

endmodule

FILE: test/tb.sv
// stimulus and verdict for the crc-checked calibration packet deframer
`timescale 1ns / 1ps

module tb;
   import cpd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [3:0] word_index, [35:4] word_value, [39:36] zero
   logic        rsp_tlast;    // last_word

   int mismatches;
   int pending;
   int words_predicted;

   // frame under construction for the sender
   logic [7:0] tx_frame[FRAME_LEN];
   int         bytes_sent;
   int         segment;
   bit         burst_mode;    // no sender gaps while set
   int         ready_hold;

   calibration_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   cpd_word_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .pending         (pending),
      .words_predicted (words_predicted)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver back-pressure, changed at the falling edge only
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready = 1'b1;
         ready_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(20, 60);
      end else begin
         rsp_tready = 1'b0;
         ready_hold = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
   end

   // crc of the stimulus frame, used only to make frames that pass
   function automatic logic [15:0] modbus_crc_update(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   // one byte transfer; called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = b;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // header, payload of the given flavour (0 random, 1 all zero, 2 all ones), crc low then high
   task automatic build_good_frame(input int flavour);
      logic [15:0] crc;
      tx_frame[0] = HDR0;
      tx_frame[1] = HDR1;
      for (int i = 2; i < FRAME_LEN - 2; i++)
         tx_frame[i] = (flavour == 1) ? 8'h00 : (flavour == 2) ? 8'hFF : 8'($urandom);
      crc = CRC_INIT;
      for (int i = 0; i < FRAME_LEN - 2; i++) crc = modbus_crc_update(crc, tx_frame[i]);
      tx_frame[FRAME_LEN-2] = crc[7:0];
      tx_frame[FRAME_LEN-1] = crc[15:8];
   endtask

   task automatic send_frame(input int first);
      for (int i = first; i < FRAME_LEN; i++) send_byte(tx_frame[i]);
   endtask

   // partial frame of gap_at bytes, then a whole good frame whose header pair lands at offset gap_at;
   // the crc fails and the block has to pick up the embedded header
   task automatic send_resync(input int gap_at);
      send_byte(HDR0);
      send_byte(HDR1);
      for (int i = 2; i < gap_at; i++) send_byte(8'($urandom));
      build_good_frame(0);
      send_frame(0);
   endtask

   task automatic run_segment(input int kind);
      int pos;
      int n;
      int r;
      case (kind)
         0: begin
            // good frame, payload sometimes at its extremes
            r = $urandom_range(0, 9);
            build_good_frame(r == 0 ? 1 : r == 1 ? 2 : 0);
            send_frame(0);
         end
         1: begin
            // one damaged byte anywhere, header and crc bytes included
            build_good_frame(0);
            pos = $urandom_range(0, FRAME_LEN - 1);
            tx_frame[pos] ^= 8'($urandom_range(1, 255));
            send_frame(0);
         end
         2: begin
            r = $urandom_range(0, 9);
            send_resync(r == 0 ? 2 : r == 1 ? FRAME_LEN - 2 : $urandom_range(2, FRAME_LEN - 2));
         end
         3: begin
            // bad frame ending in a header byte, often followed by the rest of a good one
            send_byte(HDR0);
            send_byte(HDR1);
            for (int i = 2; i < FRAME_LEN - 1; i++) send_byte(8'($urandom));
            send_byte(HDR0);
            if ($urandom_range(0, 1)) begin
               build_good_frame(0);
               send_frame(1);
            end
         end
         default: begin
            // line noise, leaning on header values
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(0, 3);
               send_byte(r == 0 ? HDR0 : r == 1 ? HDR1 : 8'($urandom));
            end
         end
      endcase
   endtask

   // hard limit on the whole run
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int r;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      rsp_tready = 1'b0;
      ready_hold = 0;
      burst_mode = 1'b0;
      bytes_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: bytes dropped while hunting, second byte wrong in several ways
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR1);          // second header byte with nothing held
      send_byte(HDR0);
      send_byte(HDR0);          // repeated first byte clears, not taken as a new start
      send_byte(HDR1);          // so this one is dropped too
      send_byte(HDR0);
      send_byte(8'h00);
      send_byte(HDR0);
      send_byte(8'hFF);

      // one fixed good frame, payload random or at an extreme
      build_good_frame($urandom_range(0, 2));
      send_frame(0);

      // random part until at least 100 bytes have been sent in all, or 40 segments
      segment = 0;
      while (bytes_sent < 100 && segment < 40) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         run_segment(r < 45 ? 0 : r < 60 ? 1 : r < 78 ? 2 : r < 90 ? 3 : 4);
         segment++;
      end
      req_tvalid = 1'b0;

      // drain, then allow for a copy-down pass still running
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/cpd_pkg.sv
rtl/core/cpd_seq.sv
rtl/core/cpd_datapath.sv
rtl/core/calibration_packet_deframer.sv
test/cpd_word_checker.sv
test/tb.sv
